@@ rtl/ps2hc_pkg.sv @@
package ps2hc_pkg;

   // Host bus access and device arrival codes.
   localparam logic [2:0] OP_READ_DATA   = 3'd0;
   localparam logic [2:0] OP_READ_STATUS = 3'd1;
   localparam logic [2:0] OP_WRITE_DATA  = 3'd2;
   localparam logic [2:0] OP_WRITE_CMD   = 3'd3;
   localparam logic [2:0] OP_LINE1_BYTE  = 3'd4;
   localparam logic [2:0] OP_LINE2_BYTE  = 3'd5;

   // Owner of the byte in the output buffer.
   localparam logic [1:0] SRC_CTRL  = 2'd0;
   localparam logic [1:0] SRC_LINE1 = 2'd1;
   localparam logic [1:0] SRC_LINE2 = 2'd2;

   // Meaning of the next data write.
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_CONF  = 2'd1;
   localparam logic [1:0] PEND_LINE2 = 2'd2;

   // Controller commands.
   localparam logic [7:0] CMD_READ_CONFIG  = 8'h20;
   localparam logic [7:0] CMD_WRITE_CONFIG = 8'h60;
   localparam logic [7:0] CMD_WRITE_LINE2  = 8'hD4;
   localparam logic [7:0] CMD_SELF_TEST    = 8'hAA;
   localparam logic [7:0] CMD_TEST_LINE1   = 8'hAB;
   localparam logic [7:0] CMD_TEST_LINE2   = 8'hA9;
   localparam logic [7:0] CMD_DIS_LINE1    = 8'hAD;
   localparam logic [7:0] CMD_ENA_LINE1    = 8'hAE;
   localparam logic [7:0] CMD_DIS_LINE2    = 8'hA7;
   localparam logic [7:0] CMD_ENA_LINE2    = 8'hA8;

   // Replies and fixed values.
   localparam logic [7:0] SELF_TEST_PASS = 8'h55;
   localparam logic [7:0] PORT_TEST_PASS = 8'h00;
   localparam logic [7:0] CONFIG_RESET   = 8'h30;

   // Configuration byte bit positions.
   localparam int CFG_IRQ1_BIT   = 0;
   localparam int CFG_IRQ2_BIT   = 1;
   localparam int CFG_SYS_BIT    = 2;
   localparam int CFG_CLKDIS1_BIT = 4;
   localparam int CFG_CLKDIS2_BIT = 5;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] bus_byte;
      logic [7:0] dev_byte;
   } ps2hc_req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       tx_valid;
      logic       tx_line;
      logic [7:0] tx_byte;
      logic       irq_first;
      logic       irq_second;
      logic       dropped;
   } ps2hc_rsp_type;

endpackage

@@ rtl/ps2hc_ctrl.sv @@
module ps2hc_ctrl
   import ps2hc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  ps2hc_req_type item,
   output ps2hc_rsp_type result
);

   logic [7:0] out_buffer_ff, out_buffer_in;
   logic       out_full_ff, out_full_in;
   logic [1:0] out_source_ff, out_source_in;
   logic [7:0] config_ff, config_in;
   logic [1:0] pending_ff, pending_in;
   logic       last_cmd_ff, last_cmd_in;
   logic [7:0] status_byte;

   // Status register as the host sees it before this item.
   always_comb begin
      status_byte = 8'h00;
      status_byte[0] = out_full_ff;
      status_byte[CFG_SYS_BIT] = config_ff[CFG_SYS_BIT];
      status_byte[3] = last_cmd_ff;
      status_byte[5] = out_full_ff && (out_source_ff == SRC_LINE2);
   end

   // Next state and result for one item.
   always_comb begin
      out_buffer_in = out_buffer_ff;
      out_full_in   = out_full_ff;
      out_source_in = out_source_ff;
      config_in     = config_ff;
      pending_in    = pending_ff;
      last_cmd_in   = last_cmd_ff;
      result        = '0;

      case (item.opcode)
         OP_READ_DATA: begin
            result.read_byte = out_buffer_ff;
            out_full_in = 1'b0;
         end
         OP_READ_STATUS: begin
            result.read_byte = status_byte;
         end
         OP_WRITE_DATA: begin
            last_cmd_in = 1'b0;
            pending_in  = PEND_NONE;
            if (pending_ff == PEND_CONF) begin
               config_in = item.bus_byte;
            end else begin
               result.tx_valid = 1'b1;
               result.tx_line  = (pending_ff == PEND_LINE2);
               result.tx_byte  = item.bus_byte;
            end
         end
         OP_WRITE_CMD: begin
            pending_in  = PEND_NONE;
            last_cmd_in = 1'b1;
            case (item.bus_byte)
               CMD_READ_CONFIG: begin
                  out_buffer_in = config_ff;
                  out_full_in   = 1'b1;
                  out_source_in = SRC_CTRL;
               end
               CMD_WRITE_CONFIG: begin
                  pending_in = PEND_CONF;
               end
               CMD_WRITE_LINE2: begin
                  pending_in = PEND_LINE2;
               end
               CMD_SELF_TEST: begin
                  out_buffer_in = SELF_TEST_PASS;
                  out_full_in   = 1'b1;
                  out_source_in = SRC_CTRL;
               end
               CMD_TEST_LINE1, CMD_TEST_LINE2: begin
                  out_buffer_in = PORT_TEST_PASS;
                  out_full_in   = 1'b1;
                  out_source_in = SRC_CTRL;
               end
               CMD_DIS_LINE1: begin
                  config_in[CFG_CLKDIS1_BIT] = 1'b1;
               end
               CMD_ENA_LINE1: begin
                  config_in[CFG_CLKDIS1_BIT] = 1'b0;
               end
               CMD_DIS_LINE2: begin
                  config_in[CFG_CLKDIS2_BIT] = 1'b1;
               end
               CMD_ENA_LINE2: begin
                  config_in[CFG_CLKDIS2_BIT] = 1'b0;
               end
               default: begin
               end
            endcase
         end
         OP_LINE1_BYTE, OP_LINE2_BYTE: begin
            // A device byte that finds the buffer full is lost.
            if (out_full_ff) begin
               result.dropped = 1'b1;
            end else begin
               out_buffer_in = item.dev_byte;
               out_full_in   = 1'b1;
               out_source_in = (item.opcode == OP_LINE1_BYTE) ? SRC_LINE1 : SRC_LINE2;
            end
         end
         default: begin
         end
      endcase

      // Interrupt levels follow the state after this item.
      result.irq_first  = out_full_in && (out_source_in == SRC_LINE1) &&
                          config_in[CFG_IRQ1_BIT];
      result.irq_second = out_full_in && (out_source_in == SRC_LINE2) &&
                          config_in[CFG_IRQ2_BIT];
   end

   // Controller state, updated once per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_buffer_ff <= 8'h00;
         out_full_ff   <= 1'b0;
         out_source_ff <= SRC_CTRL;
         config_ff     <= CONFIG_RESET;
         pending_ff    <= PEND_NONE;
         last_cmd_ff   <= 1'b0;
      end else if (step) begin
         out_buffer_ff <= out_buffer_in;
         out_full_ff   <= out_full_in;
         out_source_ff <= out_source_in;
         config_ff     <= config_in;
         pending_ff    <= pending_in;
         last_cmd_ff   <= last_cmd_in;
      end
   end

endmodule

@@ rtl/ps2_host_controller.sv @@
// A result is registered in the result register as its item leaves the input register.
// One item per cycle while the receiver does not stall; the input and result registers each
// hold one item, and the controller state updates as an item moves between them.
// Reset: synchronous, active high; clears the buffer, the full flag and the pending
// mark, and sets the configuration byte to 0x30 with both device clocks disabled.
module ps2_host_controller
   import ps2hc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  ps2hc_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ps2hc_rsp_type rsp_data
);

   logic          in_valid_ff;
   ps2hc_req_type in_data_ff;
   logic          out_valid_ff;
   ps2hc_rsp_type out_data_ff;
   logic          out_free;
   logic          advance;
   logic          req_take;
   ps2hc_rsp_type result;

   // An item moves on when the result register is empty or being drained.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   ps2hc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .result (result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // Result register; holds while the receiver stalls the transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
